// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Each macro expands to a labelled concurrent assertion in simulation and to
// nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
`define ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop)
`define ASSERT_CLK(lbl, clk, prop)
`endif

`endif

// File: rtl/dip_pkg.sv
// ----------------------------------------------------------------------------
// dip_pkg - shared types and opcodes for the Dalvik instruction predecoder
// Holds the decoded result record and the opcodes named in the decode logic.
// ----------------------------------------------------------------------------
`default_nettype none

package dip_pkg;

    // Opcodes with special handling
    localparam logic [7:0] OP_NOP          = 8'h00;
    localparam logic [7:0] OP_MOVE_16      = 8'h03;
    localparam logic [7:0] OP_MOVE_WIDE_16 = 8'h06;
    localparam logic [7:0] OP_MOVE_OBJ_16  = 8'h09;
    localparam logic [7:0] OP_RETURN_VOID  = 8'h0e;
    localparam logic [7:0] OP_RETURN_OBJ   = 8'h11;
    localparam logic [7:0] OP_GOTO         = 8'h28;
    localparam logic [7:0] OP_GOTO_16      = 8'h29;
    localparam logic [7:0] OP_GOTO_32      = 8'h2a;
    localparam logic [7:0] OP_PACKED_SW    = 8'h2b;
    localparam logic [7:0] OP_SPARSE_SW    = 8'h2c;
    localparam logic [7:0] OP_IF_FIRST     = 8'h32;
    localparam logic [7:0] OP_IF_LAST      = 8'h3d;

    // Decoded result of one item
    typedef struct packed {
        logic [2:0]         length_units;
        logic               is_payload;
        logic               writes_register;
        logic [15:0]        dest_register;
        logic               dest_wide;
        logic               is_branch;
        logic signed [31:0] branch_offset;
        logic               is_return_or_switch;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/dalvik_instruction_predecoder.sv
// ----------------------------------------------------------------------------
// dalvik_instruction_predecoder - one-instruction Dalvik predecoder
// Registers a window of three code units, decodes it and registers the result.
//
//   channel  | handshake           | payload
//   ---------+---------------------+----------------------------------------
//   input    | i_valid / o_stall   | i_first_unit, i_second_unit, i_third_unit
//   result   | o_valid / i_stall   | o_length_units ... o_is_return_or_switch
//
// One item per cycle while the result is not stalled; o_valid rises once the
// input register has taken the item at the accepting edge and the result
// register has taken its decode.
// Synchronous active-low reset empties both stages.
// o_stall rises only when both stages hold items and the result is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dalvik_instruction_predecoder (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [15:0]        i_first_unit,
    input  wire logic [15:0]        i_second_unit,
    input  wire logic [15:0]        i_third_unit,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [2:0]              o_length_units,
    output logic                    o_is_payload,
    output logic                    o_writes_register,
    output logic [15:0]             o_dest_register,
    output logic                    o_dest_wide,
    output logic                    o_is_branch,
    output logic signed [31:0]      o_branch_offset,
    output logic                    o_is_return_or_switch
);

    logic             r_in_valid;
    logic [15:0]      r_first;
    logic [15:0]      r_second;
    logic [15:0]      r_third;
    logic             r_out_valid;
    dip_pkg::t_result r_result;
    dip_pkg::t_result n_result;
    logic             out_free;
    logic             in_free;

    // Stage moves when the next one can take its item
    assign out_free = !r_out_valid || !i_stall;
    assign in_free  = !r_in_valid || out_free;
    assign o_stall  = !in_free;

    // Hold or advance the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_valid) begin
            r_first  <= i_first_unit;
            r_second <= i_second_unit;
            r_third  <= i_third_unit;
        end
    end

    dip_decode u_decode (
        .i_first_unit  (r_first),
        .i_second_unit (r_second),
        .i_third_unit  (r_third),
        .o_result      (n_result)
    );

    // Hold or advance the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_in_valid) begin
            r_result <= n_result;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_length_units        = r_result.length_units;
    assign o_is_payload          = r_result.is_payload;
    assign o_writes_register     = r_result.writes_register;
    assign o_dest_register       = r_result.dest_register;
    assign o_dest_wide           = r_result.dest_wide;
    assign o_is_branch           = r_result.is_branch;
    assign o_branch_offset       = r_result.branch_offset;
    assign o_is_return_or_switch = r_result.is_return_or_switch;

    // Accepted item lands in the input register
    `ASSERT_CLK_RST(a_in_capture, i_clk, i_rst_n, (i_valid && !o_stall) |=> r_in_valid)
    // Both stages hold while the result is stalled
    `ASSERT_CLK_RST(a_hold_full, i_clk, i_rst_n,
        (r_in_valid && r_out_valid && i_stall) |=> (r_in_valid && r_out_valid))
    // A payload marker carries no length and no destination
    `ASSERT_CLK_RST(a_payload, i_clk, i_rst_n,
        (o_valid && o_is_payload) |-> (o_length_units == 3'd0 && !o_writes_register))
    // Unused destination and offset fields read zero
    `ASSERT_CLK_RST(a_zero_fields, i_clk, i_rst_n,
        o_valid |-> ((o_writes_register || (o_dest_register == 16'h0000 && !o_dest_wide))
                     && (o_is_branch || o_branch_offset == 32'sd0)))

endmodule

`default_nettype wire

// File: rtl/dip_decode.sv
// ----------------------------------------------------------------------------
// dip_decode - opcode decode of one registered instruction window
// Gives length, payload flag, destination, branch offset and return/switch
// flag from the first three code units.
// ----------------------------------------------------------------------------
`default_nettype none

module dip_decode (
    input  wire logic [15:0]      i_first_unit,
    input  wire logic [15:0]      i_second_unit,
    input  wire logic [15:0]      i_third_unit,
    output dip_pkg::t_result      o_result
);

    function automatic logic in_rng(input logic [7:0] v, input logic [7:0] lo,
                                    input logic [7:0] hi);
        in_rng = (v >= lo) && (v <= hi);
    endfunction

    // Length in code units, zero for unused opcodes
    function automatic logic [2:0] op_length(input logic [7:0] op);
        logic [2:0] len;
        len = 3'd0;
        unique case (op)
            8'h00, 8'h01, 8'h04, 8'h07, 8'h0a, 8'h0b, 8'h0c, 8'h0d, 8'h0e,
            8'h0f, 8'h10, 8'h11, 8'h12, 8'h1d, 8'h1e, 8'h21, 8'h27, 8'h28:
                len = 3'd1;
            8'h02, 8'h05, 8'h08, 8'h13, 8'h15, 8'h16, 8'h19, 8'h1a, 8'h1c,
            8'h1f, 8'h20, 8'h22, 8'h23, 8'h29:
                len = 3'd2;
            8'h03, 8'h06, 8'h09, 8'h14, 8'h17, 8'h1b, 8'h24, 8'h25, 8'h26,
            8'h2a, 8'h2b, 8'h2c:
                len = 3'd3;
            8'h18:
                len = 3'd5;
            8'hfa, 8'hfb:
                len = 3'd4;
            default: begin
                if (in_rng(op, 8'h2d, 8'h3d) || in_rng(op, 8'h44, 8'h6d) ||
                    in_rng(op, 8'h90, 8'haf) || in_rng(op, 8'hd0, 8'he2) ||
                    op >= 8'hfe) begin
                    len = 3'd2;
                end else if (in_rng(op, 8'h6e, 8'h72) || in_rng(op, 8'h74, 8'h78) ||
                             in_rng(op, 8'hfc, 8'hfd)) begin
                    len = 3'd3;
                end else if (in_rng(op, 8'h7b, 8'h8f) || in_rng(op, 8'hb0, 8'hcf)) begin
                    len = 3'd1;
                end else begin
                    len = 3'd0;
                end
            end
        endcase
        op_length = len;
    endfunction

    // Destination held in bits 11..8
    function automatic logic dest_nibble(input logic [7:0] op);
        dest_nibble = op == 8'h01 || op == 8'h04 || op == 8'h07 || op == 8'h12 ||
                      op == 8'h20 || op == 8'h21 || op == 8'h23 ||
                      in_rng(op, 8'h52, 8'h58) || in_rng(op, 8'h7b, 8'h8f) ||
                      in_rng(op, 8'hb0, 8'hcf) || in_rng(op, 8'hd0, 8'hd7);
    endfunction

    // Destination held in bits 15..8
    function automatic logic dest_byte(input logic [7:0] op);
        dest_byte = op == 8'h02 || op == 8'h05 || op == 8'h08 ||
                    in_rng(op, 8'h0a, 8'h0d) || in_rng(op, 8'h13, 8'h1c) ||
                    op == 8'h22 || in_rng(op, 8'h2d, 8'h31) ||
                    in_rng(op, 8'h44, 8'h4a) || in_rng(op, 8'h60, 8'h66) ||
                    in_rng(op, 8'h90, 8'haf) || in_rng(op, 8'hd8, 8'he2) ||
                    op == 8'hfe || op == 8'hff;
    endfunction

    // Destination is a register pair
    function automatic logic dest_pair(input logic [7:0] op);
        dest_pair = op == 8'h04 || op == 8'h05 || op == 8'h06 || op == 8'h0b ||
                    in_rng(op, 8'h16, 8'h19) || op == 8'h45 || op == 8'h53 ||
                    op == 8'h61 || op == 8'h7d || op == 8'h7e || op == 8'h80 ||
                    op == 8'h81 || op == 8'h83 || op == 8'h86 || op == 8'h88 ||
                    op == 8'h89 || op == 8'h8b || in_rng(op, 8'h9b, 8'ha5) ||
                    in_rng(op, 8'hab, 8'haf) || in_rng(op, 8'hbb, 8'hc5) ||
                    in_rng(op, 8'hcb, 8'hcf);
    endfunction

    logic [7:0] op;
    logic [7:0] hi;

    assign op = i_first_unit[7:0];
    assign hi = i_first_unit[15:8];

    always_comb begin
        o_result = '0;

        // Length; a payload marker has no decoded length
        o_result.length_units = op_length(op);
        if (op == dip_pkg::OP_NOP && hi != 8'h00) begin
            o_result.is_payload   = 1'b1;
            o_result.length_units = 3'd0;
        end

        // Destination register
        priority if (dest_nibble(op)) begin
            o_result.writes_register = 1'b1;
            o_result.dest_register   = {12'h000, hi[3:0]};
        end else if (dest_byte(op)) begin
            o_result.writes_register = 1'b1;
            o_result.dest_register   = {8'h00, hi};
        end else if (op == dip_pkg::OP_MOVE_16 || op == dip_pkg::OP_MOVE_WIDE_16 ||
                     op == dip_pkg::OP_MOVE_OBJ_16) begin
            o_result.writes_register = 1'b1;
            o_result.dest_register   = i_second_unit;
        end else begin
            o_result.writes_register = 1'b0;
        end
        o_result.dest_wide = o_result.writes_register && dest_pair(op);

        // Relative branch offset, sign-extended
        priority if (op == dip_pkg::OP_GOTO) begin
            o_result.is_branch     = 1'b1;
            o_result.branch_offset = {{24{hi[7]}}, hi};
        end else if (op == dip_pkg::OP_GOTO_16 ||
                     in_rng(op, dip_pkg::OP_IF_FIRST, dip_pkg::OP_IF_LAST)) begin
            o_result.is_branch     = 1'b1;
            o_result.branch_offset = {{16{i_second_unit[15]}}, i_second_unit};
        end else if (op == dip_pkg::OP_GOTO_32) begin
            o_result.is_branch     = 1'b1;
            o_result.branch_offset = {i_third_unit, i_second_unit};
        end else begin
            o_result.is_branch = 1'b0;
        end

        // Returns and switches
        o_result.is_return_or_switch =
            in_rng(op, dip_pkg::OP_RETURN_VOID, dip_pkg::OP_RETURN_OBJ) ||
            op == dip_pkg::OP_PACKED_SW || op == dip_pkg::OP_SPARSE_SW;
    end

endmodule

`default_nettype wire
